/* hw/rtl/escd_pkg.sv */
// ----------------------------------------------------------------------------
// escd_pkg
// Shared types, constants and the month start table for the epoch seconds to
// calendar date converter.
// ----------------------------------------------------------------------------
package escd_pkg;

  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW  = 11;

  localparam logic [DivisorW-1:0] SecsPerMin    = 11'd60;
  localparam logic [DivisorW-1:0] MinsPerHour   = 11'd60;
  localparam logic [DivisorW-1:0] HoursPerDay   = 11'd24;
  localparam logic [DivisorW-1:0] DaysPerWeek   = 11'd7;
  localparam logic [DivisorW-1:0] DaysPerPeriod = 11'd1461;
  localparam logic [DivisorW-1:0] DaysPerYear   = 11'd365;

  localparam logic [15:0] EpochWeekday   = 16'd4;
  localparam logic [15:0] Days1968To1970 = 16'd731;
  localparam logic [10:0] LeapDayEnd     = 11'd60;
  localparam logic [10:0] LastDayOfLeap  = 11'd365;
  localparam logic [7:0]  BaseYear       = 8'd68;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
    logic [DivisorW-1:0]  remainder;
  } div_rsp_t;

  // days before month (idx = month - 1), non-leap
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      4'd12:   r = 9'd365;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/escd_div.sv */
// ----------------------------------------------------------------------------
// escd_div
// Shared constant divider. One 32x32 multiplier gives the quotient by
// reciprocal multiplication, then the remainder by multiply and subtract.
// A beat runs through load, quotient and remainder phases; done rises with the remainder.
// Exact for dividends below 2^31 (below 2^32 for 60, 24 and 1461).
// ----------------------------------------------------------------------------
module escd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  escd_pkg::div_req_t req_i,
  output escd_pkg::div_rsp_t rsp_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhQuo  = 2'd1;
  localparam logic [1:0] PhRem  = 2'd2;

  // ceil(2^S / d) for the divisor after the pre-shift
  localparam logic [31:0] RecipDiv15   = 32'd1145324613;
  localparam logic [31:0] RecipDiv3    = 32'd2863311531;
  localparam logic [31:0] RecipWeek    = 32'd2454267027;
  localparam logic [31:0] RecipPeriod  = 32'd1505149388;
  localparam logic [31:0] RecipYear    = 32'd3012360625;

  logic [1:0]                     phase_q, phase_d;
  logic                           done_q, done_d;
  logic [escd_pkg::DividendW-1:0] num_q, num_d;
  logic [escd_pkg::DivisorW-1:0]  den_q, den_d;
  logic [escd_pkg::DividendW-1:0] quo_q, quo_d;
  logic [escd_pkg::DivisorW-1:0]  rem_q, rem_d;
  logic [31:0]                    scaled;
  logic [31:0]                    recip;
  logic [31:0]                    quo_m;
  logic [31:0]                    mul_a;
  logic [31:0]                    mul_b;
  logic [63:0]                    mul_p;
  logic [31:0]                    rem_full;

  assign mul_a    = (phase_q == PhRem) ? quo_q : scaled;
  assign mul_b    = (phase_q == PhRem) ? {21'd0, den_q} : recip;
  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign rem_full = num_q - mul_p[31:0];

  always_comb begin
    unique case (den_q)
      escd_pkg::SecsPerMin: begin
        scaled = {2'd0, num_q[31:2]};
        recip  = RecipDiv15;
        quo_m  = {2'd0, mul_p[63:34]};
      end
      escd_pkg::HoursPerDay: begin
        scaled = {3'd0, num_q[31:3]};
        recip  = RecipDiv3;
        quo_m  = {1'd0, mul_p[63:33]};
      end
      escd_pkg::DaysPerWeek: begin
        scaled = num_q;
        recip  = RecipWeek;
        quo_m  = {2'd0, mul_p[63:34]};
      end
      escd_pkg::DaysPerPeriod: begin
        scaled = num_q;
        recip  = RecipPeriod;
        quo_m  = {9'd0, mul_p[63:41]};
      end
      escd_pkg::DaysPerYear: begin
        scaled = num_q;
        recip  = RecipYear;
        quo_m  = {8'd0, mul_p[63:40]};
      end
      default: begin
        scaled = num_q;
        recip  = '0;
        quo_m  = '0;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    num_d   = num_q;
    den_d   = den_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (req_i.start) begin
      phase_d = PhQuo;
      num_d   = req_i.dividend;
      den_d   = req_i.divisor;
    end else begin
      unique case (phase_q)
        PhQuo: begin
          quo_d   = quo_m;
          phase_d = PhRem;
        end
        PhRem: begin
          rem_d   = rem_full[escd_pkg::DivisorW-1:0];
          done_d  = 1'b1;
          phase_d = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* hw/rtl/epoch_seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Converts seconds since 1970-01-01 00:00 into broken-down calendar time using
// one shared constant divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | start, busy        | epoch_seconds_i
//  result   | valid_o (strobe)   | second_of_minute_o .. day_of_year_o
//
//  A beat runs six divisions on the shared divider, then a month search
//  that steps down from December until the month is found. busy is high for
//  all of it. valid_o lasts one cycle and cannot be stalled. Reset clears the
//  sequencer and the strobe only.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds_i,
  output logic        valid_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [7:0]  year_since_1900_o,
  output logic [2:0]  weekday_o,
  output logic [8:0]  day_of_year_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StWait  = 2'd2;
  localparam logic [1:0] StMonth = 2'd3;

  localparam logic [2:0] StepSec    = 3'd0;
  localparam logic [2:0] StepMin    = 3'd1;
  localparam logic [2:0] StepHour   = 3'd2;
  localparam logic [2:0] StepWday   = 3'd3;
  localparam logic [2:0] StepPeriod = 3'd4;
  localparam logic [2:0] StepYear   = 3'd5;

  logic [1:0]  state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic        valid_q, valid_d;
  logic [31:0] secs_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q;
  logic [15:0] days_q;
  logic [2:0]  wday_q;
  logic [5:0]  periods_q;
  logic [10:0] in_period_q;
  logic [8:0]  doy_q;
  logic [7:0]  year_q;
  logic [3:0]  month_q;
  logic [4:0]  dom_q;

  escd_pkg::div_req_t div_req;
  escd_pkg::div_rsp_t div_rsp;

  logic        accept;
  logic [15:0] d68;
  logic        past_leap;
  logic [8:0]  mstart;
  logic        found;

  assign accept    = start && !busy;
  assign d68       = days_q + escd_pkg::Days1968To1970;
  assign past_leap = div_rsp.remainder >= escd_pkg::LeapDayEnd;
  assign mstart    = escd_pkg::month_start(month_q - 4'd1)
                   + {8'd0, (month_q > 4'd2) && (year_q[1:0] == 2'd0)};
  assign found     = (doy_q >= mstart) || (month_q == 4'd1);

  escd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req.start = (state_q == StIssue);
    unique case (step_q)
      StepSec: begin
        div_req.dividend = secs_q;
        div_req.divisor  = escd_pkg::SecsPerMin;
      end
      StepMin: begin
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = escd_pkg::MinsPerHour;
      end
      StepHour: begin
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = escd_pkg::HoursPerDay;
      end
      StepWday: begin
        div_req.dividend = {16'd0, days_q + escd_pkg::EpochWeekday};
        div_req.divisor  = escd_pkg::DaysPerWeek;
      end
      StepPeriod: begin
        div_req.dividend = {16'd0, d68};
        div_req.divisor  = escd_pkg::DaysPerPeriod;
      end
      default: begin
        div_req.dividend = {16'd0, d68 - {10'd0, periods_q}};
        div_req.divisor  = escd_pkg::DaysPerYear;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StIssue;
          step_d  = StepSec;
        end
      end
      StIssue: state_d = StWait;
      StWait: begin
        if (div_rsp.done) begin
          if (step_q == StepYear) begin
            state_d = StMonth;
          end else begin
            state_d = StIssue;
            step_d  = step_q + 3'd1;
          end
        end
      end
      default: begin
        if (found) begin
          state_d = StIdle;
          valid_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepSec;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      secs_q <= epoch_seconds_i;
    end
    if (state_q == StWait && div_rsp.done) begin
      unique case (step_q)
        StepSec:  sec_q  <= div_rsp.remainder[5:0];
        StepMin:  min_q  <= div_rsp.remainder[5:0];
        StepHour: begin
          hour_q <= div_rsp.remainder[4:0];
          days_q <= div_rsp.quotient[15:0];
        end
        StepWday: wday_q <= div_rsp.remainder[2:0];
        StepPeriod: begin
          periods_q   <= div_rsp.quotient[5:0] + {5'd0, past_leap};
          in_period_q <= div_rsp.remainder;
        end
        default: begin
          year_q  <= div_rsp.quotient[7:0] + escd_pkg::BaseYear;
          doy_q   <= div_rsp.remainder[8:0]
                   + {8'd0, (in_period_q >= escd_pkg::LeapDayEnd)
                            && (in_period_q <= escd_pkg::LastDayOfLeap)};
          month_q <= 4'd12;
        end
      endcase
    end
    if (state_q == StMonth) begin
      if (found) begin
        dom_q <= 5'(doy_q - mstart + 9'd1);
      end else begin
        month_q <= month_q - 4'd1;
      end
    end
  end

  assign busy               = (state_q != StIdle);
  assign valid_o            = valid_q;
  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign day_of_month_o     = dom_q;
  assign month_number_o     = month_q;
  assign year_since_1900_o  = year_q;
  assign weekday_o          = wday_q;
  assign day_of_year_o      = doy_q;

endmodule

/* hw/rtl/escd_chk.sv */
// ----------------------------------------------------------------------------
// escd_chk
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module escd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [5:0]  second_of_minute_o,
  input logic [5:0]  minute_of_hour_o,
  input logic [4:0]  hour_of_day_o,
  input logic [3:0]  month_number_o,
  input logic [2:0]  weekday_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("busy dropped without a result");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> second_of_minute_o < 6'd60 && minute_of_hour_o < 6'd60
             && hour_of_day_o < 5'd24 && month_number_o >= 4'd1
             && month_number_o <= 4'd12 && weekday_o < 3'd7)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_date escd_chk u_escd_chk (.*);

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epoch seconds to calendar date converter.
// Directed beats at the field edges, leap days and the year 2100 boundary,
// then random beats under varying start idling, each checked field by field
// against a local calendar model.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned BeatsPerPhase = 340;
  localparam int unsigned SecsPerDay = 86400;
  localparam int unsigned LastFullDay = 49709;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] mnt;
    logic [4:0] hr;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] year;
    logic [2:0] wday;
    logic [8:0] yday;
  } cal_t;

  class calendar_board;
    cal_t         dates_due[$];
    int unsigned  fail_count;
    int unsigned  days_before[13];

    function new();
      days_before = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
      fail_count  = 0;
    endfunction

    function int unsigned month_offset(int unsigned mon, int unsigned year);
      return days_before[mon-1] + (((mon > 2) && (year % 4 == 0)) ? 1 : 0);
    endfunction

    function cal_t convert(bit [31:0] secs);
      cal_t        r;
      int unsigned mins, hours, days, d68, quads, in_quad, years, yday, year;
      int unsigned mon, first;
      mins  = secs / 60;
      hours = mins / 60;
      days  = hours / 24;
      // count days from 1968 so each four-year block starts with a leap year
      d68     = days + 731;
      quads   = d68 / 1461;
      in_quad = d68 % 1461;
      if (in_quad >= 60) quads++;
      years = (d68 - quads) / 365;
      yday  = d68 - years * 365 - quads;
      if (in_quad >= 60 && in_quad <= 365) yday++;
      year  = years + 68;
      mon   = 12;
      first = month_offset(mon, year);
      while (mon > 1 && yday < first) begin
        mon--;
        first = month_offset(mon, year);
      end
      r.sec  = 6'(secs - mins * 60);
      r.mnt  = 6'(mins - hours * 60);
      r.hr   = 5'(hours - days * 24);
      r.mday = 5'(yday - first + 1);
      r.mon  = 4'(mon);
      r.year = 8'(year);
      r.wday = 3'((days + 4) % 7);
      r.yday = 9'(yday);
      return r;
    endfunction

    function void note_input(bit [31:0] secs);
      dates_due.push_back(convert(secs));
    endfunction

    function void report(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    function void check_result(cal_t got);
      cal_t exp_d;
      if (dates_due.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $realtime, got);
        fail_count++;
        return;
      end
      exp_d = dates_due.pop_front();
      report("second_of_minute", 32'(exp_d.sec), 32'(got.sec));
      report("minute_of_hour", 32'(exp_d.mnt), 32'(got.mnt));
      report("hour_of_day", 32'(exp_d.hr), 32'(got.hr));
      report("day_of_month", 32'(exp_d.mday), 32'(got.mday));
      report("month_number", 32'(exp_d.mon), 32'(got.mon));
      report("year_since_1900", 32'(exp_d.year), 32'(got.year));
      report("weekday", 32'(exp_d.wday), 32'(got.wday));
      report("day_of_year", 32'(exp_d.yday), 32'(got.yday));
    endfunction

    function int unsigned pending();
      return dates_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] epoch_seconds_i = '0;
  logic        valid_o;
  logic [5:0]  second_of_minute_o;
  logic [5:0]  minute_of_hour_o;
  logic [4:0]  hour_of_day_o;
  logic [4:0]  day_of_month_o;
  logic [3:0]  month_number_o;
  logic [7:0]  year_since_1900_o;
  logic [2:0]  weekday_o;
  logic [8:0]  day_of_year_o;

  calendar_board board;
  int unsigned   cycle_count = 0;

  epoch_seconds_to_calendar_date DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .epoch_seconds_i    (epoch_seconds_i),
    .valid_o            (valid_o),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .day_of_month_o     (day_of_month_o),
    .month_number_o     (month_number_o),
    .year_since_1900_o  (year_since_1900_o),
    .weekday_o          (weekday_o),
    .day_of_year_o      (day_of_year_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && board != null) begin
      board.check_result('{second_of_minute_o, minute_of_hour_o, hour_of_day_o,
                           day_of_month_o, month_number_o, year_since_1900_o,
                           weekday_o, day_of_year_o});
    end
  end

  // start stays high from one beat to the next unless an idle gap is drawn
  task automatic send_beat(input bit [31:0] secs, input int unsigned idle_pct);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start           <= 1'b0;
      epoch_seconds_i <= $urandom;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (busy);
    board.note_input(secs);
  endtask

  function automatic bit [31:0] pick_seconds();
    int unsigned day, kind;
    kind = $urandom_range(9);
    day  = $urandom_range(LastFullDay);
    case (kind)
      0, 1:    return day * SecsPerDay;
      2, 3:    return day * SecsPerDay + SecsPerDay - 1;
      4: begin
        // around the end of February and the year end of 1970 and every fourth year after
        day = ($urandom_range(33) * 1461) + $urandom_range(57, 61);
        if ($urandom_range(1)) day = day + $urandom_range(362, 366) - 59;
        if (day > LastFullDay) day = LastFullDay;
        return day * SecsPerDay + $urandom_range(SecsPerDay - 1);
      end
      default: return $urandom;
    endcase
  endfunction

  bit [31:0]   directed_secs[$];
  int unsigned phase_idle[4];

  initial begin
    board = new();
    directed_secs = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                      32'd86399, 32'd86400, 32'd68169600, 32'd68256000,
                      32'd94608000, 32'd946684799, 32'd946684800,
                      32'd4102444800, 32'd4107542400, 32'd4107628800,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'd951782400, 32'd1234567890};
    phase_idle = '{0, 46, 30, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_secs[i]) send_beat(directed_secs[i], 0);
    foreach (phase_idle[p]) begin
      repeat (BeatsPerPhase) send_beat(pick_seconds(), phase_idle[p]);
    end
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
